### rtl/its_pkg.sv
// Package for the idle-timeout scheduler: item and result codes, the table
// entry type and the packed result type.
// No dependencies; imported by its_table and idle_timeout_scheduler_unit.
package its_pkg;

    // Field widths of the stream items.
    localparam int ID_W       = 8;
    localparam int TMO_W      = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    // Input item kinds.
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_ENABLE  = 2'd1;
    localparam logic [1:0] KIND_DISABLE = 2'd2;

    // Result kinds.
    localparam logic [1:0] RES_FIRE    = 2'd0;
    localparam logic [1:0] RES_RESCHED = 2'd1;
    localparam logic [1:0] RES_RETRY   = 2'd2;

    // One record of the sorted table.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TMO_W-1:0] timeout;
    } entry_t;

    // One result item as held in the output register.
    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  id;
        logic [TMO_W-1:0] delay;
        logic             last;
    } result_t;

endpackage

### rtl/its_table.sv
// Record table of the idle-timeout scheduler: one write port and one read
// port with registered read data.
// Depends on its_pkg for the entry type.
module its_table #(
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic           aclk,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  its_pkg::entry_t wr_data,
    input  logic [AW-1:0]  rd_addr,
    output its_pkg::entry_t rd_data
);
    import its_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered: data appears in the cycle after the address.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/idle_timeout_scheduler_unit.sv
// Top level of the idle-timeout scheduler: item capture, the sequencer that
// walks the sorted record table, and the result output register.
// Depends on its_pkg and its_table.
//
// Usage:
// Input items arrive on the s_ stream: s_tuser carries the kind (tick,
// enable, disable), s_tdata the record and idle-time fields. Result items
// leave on the m_ stream: one fire item per record reached, then one
// reschedule item (or a single retry item when idle time is unknown) if
// records are held, with m_tlast high on the final result of an input item.
// The block takes one item at a time; s_tready is low while it works.
// A tick, and an enable or disable that changes the table, is followed by a
// scheduling pass; an enable first scans and moves the held records, a
// disable scans them and closes the gap. Ignored items start no pass.
// Results pass through one output register; when the receiver stalls, the
// sequencer holds until that register is free, and no result is lost.
// Reset (aresetn low, synchronous) empties the table and clears the fire
// pointer; no clearing pass is needed, and s_tready is high right after.
module idle_timeout_scheduler_unit #(
    parameter int MAX_RECORDS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: record_id[7:0], record_timeout[23:8], idle_valid[24],
    // idle_seconds[40:25], zero padding[47:41]
    input  logic [its_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: kind[1:0]
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata: fired_id[7:0], next_delay[23:8]
    output logic [its_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: result_kind[1:0]
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import its_pkg::*;

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int AW = $clog2(MAX_RECORDS);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

    // Sequencer states.
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SCAN_RD   = 5'd1;
    localparam logic [4:0] S_SCAN_CHK  = 5'd2;
    localparam logic [4:0] S_INS_RD    = 5'd3;
    localparam logic [4:0] S_INS_WR    = 5'd4;
    localparam logic [4:0] S_INS_PUT   = 5'd5;
    localparam logic [4:0] S_INS_NRD   = 5'd6;
    localparam logic [4:0] S_INS_NCHK  = 5'd7;
    localparam logic [4:0] S_DEL_RD    = 5'd8;
    localparam logic [4:0] S_DEL_WR    = 5'd9;
    localparam logic [4:0] S_PASS      = 5'd10;
    localparam logic [4:0] S_PASS_CHK  = 5'd11;
    localparam logic [4:0] S_FIRE_RD   = 5'd12;
    localparam logic [4:0] S_FIRE_CHK  = 5'd13;
    localparam logic [4:0] S_FIRE_EMIT = 5'd14;
    localparam logic [4:0] S_HEAD_CHK  = 5'd15;
    localparam logic [4:0] S_RESCHED   = 5'd16;
    localparam logic [4:0] S_RETRY     = 5'd17;

    logic [4:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    next_reg, next_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic             pos_found_reg, pos_found_next;
    logic [1:0]       kind_reg, kind_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [TMO_W-1:0] tmo_reg, tmo_next;
    logic             valid_reg, valid_next;
    logic [TMO_W-1:0] idle_reg, idle_next;
    logic [ID_W-1:0]  cur_id_reg, cur_id_next;
    logic [TMO_W-1:0] cand_reg, cand_next;
    logic             has_cand_reg, has_cand_next;

    // Table port.
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    entry_t           wr_data;
    logic [AW-1:0]    rd_addr;
    entry_t           rd_data;

    // Output register.
    logic             m_tvalid_reg;
    result_t          m_res_reg;
    logic             out_load;
    result_t          out_res;
    logic             out_free;

    // Input fields.
    logic [1:0]       in_kind;
    logic [ID_W-1:0]  in_id;
    logic [TMO_W-1:0] in_tmo;
    logic             in_valid;
    logic [TMO_W-1:0] in_idle;

    // Derived indexes.
    logic [CW-1:0]    idx_m1;
    logic [CW-1:0]    idx_p1;
    logic [CW-1:0]    next_p1;
    logic [CW-1:0]    cnt_m1;
    logic [CW-1:0]    nclamp;
    logic [CW-1:0]    nclamp_m1;

    assign in_kind  = s_tuser;
    assign in_id    = s_tdata[7:0];
    assign in_tmo   = s_tdata[23:8];
    assign in_valid = s_tdata[24];
    assign in_idle  = s_tdata[40:25];

    assign idx_m1    = idx_reg - 1'b1;
    assign idx_p1    = idx_reg + 1'b1;
    assign next_p1   = next_reg + 1'b1;
    assign cnt_m1    = count_reg - 1'b1;
    assign nclamp    = (next_reg > count_reg) ? count_reg : next_reg;
    assign nclamp_m1 = nclamp - 1'b1;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    its_table #(
        .DEPTH (MAX_RECORDS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: scan, insert, remove, then the scheduling pass.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        next_next      = next_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        pos_found_next = pos_found_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        tmo_next       = tmo_reg;
        valid_next     = valid_reg;
        idle_next      = idle_reg;
        cur_id_next    = cur_id_reg;
        cand_next      = cand_reg;
        has_cand_next  = has_cand_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data;
        out_load       = 1'b0;
        out_res        = '{kind: RES_RETRY, id: '0, delay: '0, last: 1'b1};

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next      = in_kind;
                    id_next        = in_id;
                    tmo_next       = in_tmo;
                    valid_next     = in_valid;
                    idle_next      = in_idle;
                    idx_next       = '0;
                    pos_found_next = 1'b0;
                    unique case (in_kind)
                        KIND_TICK: begin
                            state_next = S_PASS;
                        end
                        KIND_ENABLE: begin
                            if (in_tmo != '0 && count_reg < MAX_CNT) begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        KIND_DISABLE: begin
                            if (in_tmo != '0) begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Walk the table for a duplicate id or the insert position, or for the record to remove.
            S_SCAN_RD: begin
                if (idx_reg == count_reg) begin
                    if (kind_reg == KIND_ENABLE) begin
                        if (!pos_found_reg) begin
                            pos_next = count_reg;
                        end
                        idx_next   = count_reg;
                        state_next = S_INS_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK: begin
                idx_next   = idx_p1;
                state_next = S_SCAN_RD;
                if (kind_reg == KIND_ENABLE) begin
                    if (rd_data.id == id_reg) begin
                        state_next = S_IDLE;
                    end else if (!pos_found_reg && tmo_reg < rd_data.timeout) begin
                        pos_next       = idx_reg;
                        pos_found_next = 1'b1;
                    end
                end else if (rd_data.id == id_reg) begin
                    pos_next = idx_reg;
                    idx_next = idx_reg;
                    if (idx_reg < next_reg) begin
                        next_next = next_reg - 1'b1;
                    end
                    state_next = S_DEL_RD;
                end
            end

            // Move entries up by one from the end down to the insert position.
            S_INS_RD: begin
                if (idx_reg == pos_reg) begin
                    state_next = S_INS_PUT;
                end else begin
                    rd_addr    = idx_m1[AW-1:0];
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR: begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                idx_next   = idx_m1;
                state_next = S_INS_RD;
            end

            // Place the new record and decide whether the pointer moves to it.
            S_INS_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_data    = '{id: id_reg, timeout: tmo_reg};
                count_next = count_reg + 1'b1;
                if (next_reg >= count_reg) begin
                    next_next  = pos_reg;
                    state_next = S_PASS;
                end else begin
                    state_next = S_INS_NRD;
                end
            end

            S_INS_NRD: begin
                rd_addr    = next_p1[AW-1:0];
                state_next = S_INS_NCHK;
            end

            S_INS_NCHK: begin
                if (tmo_reg < rd_data.timeout) begin
                    next_next = pos_reg;
                end
                state_next = S_PASS;
            end

            // Close the gap left by a removed record.
            S_DEL_RD: begin
                if (idx_p1 >= count_reg) begin
                    count_next = cnt_m1;
                    if (next_reg > cnt_m1) begin
                        next_next = cnt_m1;
                    end
                    state_next = S_PASS;
                end else begin
                    rd_addr    = idx_p1[AW-1:0];
                    state_next = S_DEL_WR;
                end
            end

            S_DEL_WR: begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                idx_next   = idx_p1;
                state_next = S_DEL_RD;
            end

            // Scheduling pass: check whether idle time fell below the last fired record.
            S_PASS: begin
                if (count_reg == '0) begin
                    state_next = S_IDLE;
                end else if (!valid_reg) begin
                    state_next = S_RETRY;
                end else begin
                    next_next = nclamp;
                    if (nclamp != '0) begin
                        rd_addr    = nclamp_m1[AW-1:0];
                        state_next = S_PASS_CHK;
                    end else begin
                        state_next = S_FIRE_RD;
                    end
                end
            end

            S_PASS_CHK: begin
                if (rd_data.timeout > idle_reg) begin
                    next_next = '0;
                end
                state_next = S_FIRE_RD;
            end

            // Fire every record whose timeout the idle time has reached.
            S_FIRE_RD: begin
                if (next_reg < count_reg) begin
                    rd_addr    = next_reg[AW-1:0];
                    state_next = S_FIRE_CHK;
                end else begin
                    has_cand_next = 1'b0;
                    state_next    = S_HEAD_CHK;
                end
            end

            S_FIRE_CHK: begin
                if (rd_data.timeout <= idle_reg) begin
                    cur_id_next = rd_data.id;
                    state_next  = S_FIRE_EMIT;
                end else begin
                    cand_next     = rd_data.timeout - idle_reg;
                    has_cand_next = 1'b1;
                    state_next    = S_HEAD_CHK;
                end
            end

            S_FIRE_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_res    = '{kind: RES_FIRE, id: cur_id_reg, delay: '0, last: 1'b0};
                    next_next  = next_p1;
                    state_next = S_FIRE_RD;
                end
            end

            // Delay is the smaller of the first timeout and the time to the next record.
            S_HEAD_CHK: begin
                if (has_cand_reg && cand_reg < rd_data.timeout) begin
                    cand_next = cand_reg;
                end else begin
                    cand_next = rd_data.timeout;
                end
                state_next = S_RESCHED;
            end

            S_RESCHED: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_res    = '{kind: RES_RESCHED, id: '0, delay: cand_reg, last: 1'b1};
                    state_next = S_IDLE;
                end
            end

            S_RETRY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_res    = '{kind: RES_RETRY, id: '0, delay: '0, last: 1'b1};
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            next_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            next_reg  <= next_next;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        pos_found_reg <= pos_found_next;
        kind_reg      <= kind_next;
        id_reg        <= id_next;
        tmo_reg       <= tmo_next;
        valid_reg     <= valid_next;
        idle_reg      <= idle_next;
        cur_id_reg    <= cur_id_next;
        cand_reg      <= cand_next;
        has_cand_reg  <= has_cand_next;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_res_reg <= out_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tdata  = {m_res_reg.delay, m_res_reg.id};
    assign m_tlast  = m_res_reg.last;

`ifndef SYNTHESIS
    // The fire pointer never runs past the end of the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        next_reg <= count_reg)
    else $error("fire pointer beyond entry count");

    // The table never holds more records than it has room for.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
    else $error("entry count above table depth");

    // A result is only loaded when the output register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
    else $error("result overwrote a pending result");

    // One item adds or removes at most one record.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + CW'(1) ||
             count_reg == $past(count_reg) - CW'(1)))
    else $error("entry count jumped");

    // Fire results are never the final result of an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_res.kind == RES_FIRE) |-> !out_res.last)
    else $error("fire result marked last");
`endif

endmodule
